@@ rtl/core/dcq_pkg.sv @@
// Shared types and constants for the door contact qualifier.
package dcq_pkg;

    localparam int TIMER_BITS  = 16;
    localparam int MAX_SAMPLES = 64;
    localparam int CNT_W       = 7;
    localparam int ADDR_W      = 5;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QLVL_W      = $clog2(QDEPTH + 1);

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
    localparam logic [CNT_W-1:0] SAMPLES_CAP = CNT_W'(MAX_SAMPLES);

    // register indexes (byte address 4*index)
    localparam logic [2:0] REG_DEBOUNCE = 3'd0;
    localparam logic [2:0] REG_CONFIRM  = 3'd1;
    localparam logic [2:0] REG_INTERVAL = 3'd2;
    localparam logic [2:0] REG_SCOUNT   = 3'd3;
    localparam logic [2:0] REG_LOWMIN   = 3'd4;

    // door_event codes
    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_OPENED = 2'd1;
    localparam logic [1:0] EV_CLOSED = 2'd2;

    typedef struct packed {
        logic [15:0]      debounce;
        logic [15:0]      confirm_delay;
        logic [15:0]      interval;
        logic [CNT_W-1:0] sample_count;
        logic [CNT_W-1:0] low_min;
    } t_cfg;

    // one classified tick as it travels from front to back
    typedef struct packed {
        logic pin;
        logic edge_ok;
    } t_tick;

endpackage

@@ rtl/core/dcq_cfg.sv @@
// APB register file holding the qualifier settings.
module dcq_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_psel,
    input  logic                      i_penable,
    input  logic                      i_pwrite,
    input  logic [dcq_pkg::ADDR_W-1:0] i_paddr,
    input  logic [31:0]               i_pwdata,
    output logic [31:0]               o_prdata,
    output dcq_pkg::t_cfg             o_cfg
);
    import dcq_pkg::*;

    t_cfg       r_cfg;
    logic       s_wr;
    logic [2:0] s_idx;

    assign s_wr  = i_psel && i_penable && i_pwrite;
    assign s_idx = i_paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce      <= 16'd50;
            r_cfg.confirm_delay <= 16'd100;
            r_cfg.interval      <= 16'd10;
            r_cfg.sample_count  <= CNT_W'(10);
            r_cfg.low_min       <= CNT_W'(8);
        end else if (s_wr) begin
            case (s_idx)
                REG_DEBOUNCE: r_cfg.debounce      <= i_pwdata[15:0];
                REG_CONFIRM:  r_cfg.confirm_delay <= i_pwdata[15:0];
                REG_INTERVAL: r_cfg.interval      <= i_pwdata[15:0];
                REG_SCOUNT:   r_cfg.sample_count  <= i_pwdata[CNT_W-1:0];
                REG_LOWMIN:   r_cfg.low_min       <= i_pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (s_idx)
            REG_DEBOUNCE: o_prdata = {16'd0, r_cfg.debounce};
            REG_CONFIRM:  o_prdata = {16'd0, r_cfg.confirm_delay};
            REG_INTERVAL: o_prdata = {16'd0, r_cfg.interval};
            REG_SCOUNT:   o_prdata = {{(32-CNT_W){1'b0}}, r_cfg.sample_count};
            REG_LOWMIN:   o_prdata = {{(32-CNT_W){1'b0}}, r_cfg.low_min};
            default:      o_prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/core/dcq_front.sv @@
// Front end: edge detection and debounce check on each accepted tick.
module dcq_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic           i_pin,
    input  logic [15:0]    i_debounce,
    output dcq_pkg::t_tick o_tick
);
    import dcq_pkg::*;

    logic                  r_prev_pin;
    logic [TIMER_BITS-1:0] r_since;
    logic [TIMER_BITS-1:0] s_since_inc;
    logic                  s_edge_ok;

    assign s_since_inc = (r_since != TIMER_MAX) ? r_since + 1'b1 : r_since;
    assign s_edge_ok   = (i_pin != r_prev_pin) &&
                         ((s_since_inc >= TIMER_BITS'(i_debounce)) ||
                          (s_since_inc == TIMER_MAX));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_pin <= 1'b1;
            r_since    <= '0;
        end else if (i_accept) begin
            r_prev_pin <= i_pin;
            r_since    <= s_edge_ok ? '0 : s_since_inc;
        end
    end

    assign o_tick.pin     = i_pin;
    assign o_tick.edge_ok = s_edge_ok;

endmodule

@@ rtl/core/dcq_queue.sv @@
// Short FIFO of classified ticks between front and back.
module dcq_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  dcq_pkg::t_tick             i_data,
    input  logic                       i_pop,
    output dcq_pkg::t_tick             o_data,
    output logic                       o_empty,
    output logic                       o_full,
    output logic [dcq_pkg::QLVL_W-1:0] o_level
);
    import dcq_pkg::*;

    t_tick             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QLVL_W-1:0] r_level;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        ptr_inc = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            if (i_push) r_wptr <= ptr_inc(r_wptr);
            if (i_pop)  r_rptr <= ptr_inc(r_rptr);
            if (i_push && !i_pop)      r_level <= r_level + 1'b1;
            else if (i_pop && !i_push) r_level <= r_level - 1'b1;
        end
    end

    assign o_data  = r_mem[r_rptr];
    assign o_empty = (r_level == '0);
    assign o_full  = (r_level == QLVL_W'(QDEPTH));
    assign o_level = r_level;

endmodule

@@ rtl/core/dcq_back.sv @@
// Back end: confirmation sequencer and registered result stage.
module dcq_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  dcq_pkg::t_cfg  i_cfg,
    input  dcq_pkg::t_tick i_tick,
    input  logic           i_tick_avail,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [1:0]     o_event,
    output logic           o_closed
);
    import dcq_pkg::*;

    typedef enum logic [1:0] {PH_IDLE, PH_DELAY, PH_SAMPLE} t_phase;

    t_phase                r_phase, n_phase;
    logic                  r_pending, n_pending;
    logic [TIMER_BITS-1:0] r_timer, n_timer;
    logic [CNT_W-1:0]      r_taken, n_taken;
    logic [CNT_W-1:0]      r_low, n_low;
    logic                  r_closed, n_closed;
    logic [1:0]            r_event, n_event;
    logic                  r_valid;

    logic [CNT_W-1:0]      s_count;
    logic [15:0]           s_iv;
    logic                  s_pend;
    logic                  s_decide_closed;

    assign o_pop   = i_tick_avail && (!r_valid || i_ready);
    assign s_count = (i_cfg.sample_count > SAMPLES_CAP) ? SAMPLES_CAP : i_cfg.sample_count;
    assign s_iv    = (i_cfg.interval == 16'd0) ? 16'd1 : i_cfg.interval;
    assign s_pend  = r_pending || i_tick.edge_ok;
    assign s_decide_closed = (r_low >= i_cfg.low_min);

    always_comb begin
        n_phase   = r_phase;
        n_pending = s_pend;
        n_timer   = r_timer;
        n_taken   = r_taken;
        n_low     = r_low;
        n_closed  = r_closed;
        n_event   = EV_NONE;
        case (r_phase)
            PH_IDLE: begin
                if (s_pend) begin
                    n_pending = 1'b0;
                    n_phase   = PH_DELAY;
                    n_timer   = TIMER_BITS'(i_cfg.confirm_delay);
                end
            end
            PH_DELAY: begin
                if (r_timer == '0) begin
                    n_phase = PH_SAMPLE;
                    n_taken = '0;
                    n_low   = '0;
                    if (s_count != '0) begin
                        n_taken = CNT_W'(1);
                        n_low   = CNT_W'(!i_tick.pin);
                        n_timer = TIMER_BITS'(s_iv - 16'd1);
                    end
                end else begin
                    n_timer = r_timer - 1'b1;
                end
            end
            PH_SAMPLE: begin
                if (r_timer != '0) begin
                    n_timer = r_timer - 1'b1;
                end else if (r_taken < s_count) begin
                    n_taken = r_taken + 1'b1;
                    n_low   = r_low + CNT_W'(!i_tick.pin);
                    n_timer = TIMER_BITS'(s_iv - 16'd1);
                end else begin
                    if (s_decide_closed != r_closed) begin
                        n_closed = s_decide_closed;
                        n_event  = s_decide_closed ? EV_CLOSED : EV_OPENED;
                    end
                    n_phase = PH_IDLE;
                    n_timer = '0;
                end
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_pending <= 1'b0;
            r_timer   <= '0;
            r_taken   <= '0;
            r_low     <= '0;
            r_closed  <= 1'b1;
            r_event   <= EV_NONE;
            r_valid   <= 1'b0;
        end else if (o_pop) begin
            r_phase   <= n_phase;
            r_pending <= n_pending;
            r_timer   <= n_timer;
            r_taken   <= n_taken;
            r_low     <= n_low;
            r_closed  <= n_closed;
            r_event   <= n_event;
            r_valid   <= 1'b1;
        end else if (i_ready) begin
            r_valid   <= 1'b0;
        end
    end

    assign o_valid  = r_valid;
    assign o_event  = r_event;
    assign o_closed = r_closed;

endmodule

@@ rtl/core/door_contact_qualifier.sv @@
// Top level of the door contact qualifier: front, tick queue, back, registers.
//
//  channel   direction  payload (low bit first)               handshake
//  s         in         tdata[0] pin_level                    i_s_tvalid/o_s_tready
//  m         out        tdata[1:0] door_event, [2] closed     o_m_tvalid/i_m_tready
//  apb       in/out     5 settings at byte address 4*index    psel/penable, pready=1
//
// One tick per clock sustained while the m channel takes results; each result is
// registered: its tick passes through the queue, then the result register.
// The two-entry tick queue lets the front keep taking ticks while a result
// stalls; o_s_tready drops only when the queue is full.
// Synchronous active-low reset; settings return to their defaults, door closed.
module door_contact_qualifier (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [7:0]                 i_s_tdata,   // [0] pin_level
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [7:0]                 o_m_tdata,   // [1:0] door_event, [2] door_closed
    input  logic                       i_psel,
    input  logic                       i_penable,
    input  logic                       i_pwrite,
    input  logic [dcq_pkg::ADDR_W-1:0] i_paddr,
    input  logic [31:0]                i_pwdata,
    output logic [31:0]                o_prdata,
    output logic                       o_pready
);
    import dcq_pkg::*;

    t_cfg              s_cfg;
    t_tick             s_front_tick;
    t_tick             s_back_tick;
    logic              s_accept;
    logic              s_pop;
    logic              s_empty;
    logic              s_full;
    logic [QLVL_W-1:0] s_level;
    logic [1:0]        s_event;
    logic              s_closed;

    assign o_pready   = 1'b1;
    assign o_s_tready = !s_full;
    assign s_accept   = i_s_tvalid && !s_full;

    dcq_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_cfg     (s_cfg)
    );

    dcq_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (s_accept),
        .i_pin      (i_s_tdata[0]),
        .i_debounce (s_cfg.debounce),
        .o_tick     (s_front_tick)
    );

    dcq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_accept),
        .i_data  (s_front_tick),
        .i_pop   (s_pop),
        .o_data  (s_back_tick),
        .o_empty (s_empty),
        .o_full  (s_full),
        .o_level (s_level)
    );

    dcq_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (s_cfg),
        .i_tick       (s_back_tick),
        .i_tick_avail (!s_empty),
        .o_pop        (s_pop),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_event      (s_event),
        .o_closed     (s_closed)
    );

    assign o_m_tdata = {5'd0, s_closed, s_event};

    a_closed_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && s_event == EV_CLOSED) |-> s_closed)
        else $error("closed event without closed state");

    a_opened_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && s_event == EV_OPENED) |-> !s_closed)
        else $error("opened event with closed state");

    a_state_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_closed != $past(s_closed)) |-> (s_event != EV_NONE))
        else $error("door state changed without an event");

    a_queue_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_level <= QLVL_W'(QDEPTH)) && !(s_pop && s_empty))
        else $error("tick queue level out of range");

endmodule
